>>> src/rys_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rys_pkg
// Shared types, codes and constants of the rgb to ycbcr subsampler.
// ----------------------------------------------------------------------------
package rys_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // size compare width, covers the largest legal frame size
  localparam int SIZE_W   = 14;
  localparam int POS_W    = 12;
  localparam int SAMPLE_W = 10;
  localparam int COMP_W   = 10;
  localparam int PROD_W   = 28;
  localparam int ABS_W    = 27;
  localparam int CHR_W    = 11;
  localparam int SUM_W    = 13;
  localparam int PIX_W    = 64;
  localparam int CFG_W    = 13;

  // divide by 100000 as multiply by reciprocal and shift
  localparam logic [PROD_W-1:0] RECIP    = 28'd175921861;
  localparam int                RECIP_SH = 44;

  // bt.709 full range weights, rows y, cb, cr and columns r, g, b
  localparam logic signed [PROD_W-1:0] COEF [3][3] = '{
    '{ 28'sd21260,  28'sd71520,  28'sd7220},
    '{-28'sd11458, -28'sd38542,  28'sd50000},
    '{ 28'sd50000, -28'sd45415, -28'sd4585}
  };

  typedef enum logic [2:0] {
    CFG_SOURCE_FORMAT = 3'd0,
    CFG_DEEP_OUTPUT   = 3'd1,
    CFG_CHROMA_LAYOUT = 3'd2,
    CFG_FRAME_WIDTH   = 3'd3,
    CFG_FRAME_HEIGHT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FMT_RGB8    = 3'd0,
    FMT_RGB10   = 3'd1,
    FMT_RGB16   = 3'd2,
    FMT_RGBA8   = 3'd3,
    FMT_RGB10A2 = 3'd4,
    FMT_RGBA16  = 3'd5
  } fmt_e;

  typedef enum logic [1:0] {
    LAYOUT_400 = 2'd0,
    LAYOUT_420 = 2'd1,
    LAYOUT_422 = 2'd2,
    LAYOUT_444 = 2'd3
  } layout_e;

  typedef enum logic [1:0] {
    PLANE_Y  = 2'd0,
    PLANE_CB = 2'd1,
    PLANE_CR = 2'd2
  } plane_e;

  // per pixel control decided at the input
  typedef struct packed {
    logic [2:0]       fmt;
    logic             deep;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] ccol;
    logic [POS_W-1:0] crow;
    logic             last_frame;
    logic             chroma_out;
    logic             pend_wr;
    logic             line_wr;
    logic             use_pend;
    logic             use_line;
    logic [1:0]       avg_sh;
  } ctl_t;

  // finished results of one pixel
  typedef struct packed {
    logic [SAMPLE_W-1:0] y_val;
    logic [SAMPLE_W-1:0] cb_val;
    logic [SAMPLE_W-1:0] cr_val;
    logic [POS_W-1:0]    col;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    ccol;
    logic [POS_W-1:0]    crow;
    logic                chroma_out;
    logic                last_frame;
  } item_t;

endpackage
`default_nettype wire

>>> src/rgb_to_ycbcr_subsampler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_subsampler
// Packed rgb pixels in, full range bt.709 luma and subsampled chroma out.
// ----------------------------------------------------------------------------
// One pixel enters per cycle, unless the pipe stalls, into a four register pipe
// (input register, products, sums, reciprocal divide), and the chroma averaging
// after the last of them feeds an output register that sends one sample per
// cycle while the port is ready. A pixel thus makes one output request when it
// yields luma only and three when it also closes a chroma sample
// (every pixel in 4:4:4, every second pixel of a row in 4:2:2 and of the bottom
// row of a pair in 4:2:0); the output port sets the rate. The luma request is
// offered once the pixel has passed the input, product, sum and divide registers
// and been loaded into the output register. The 4:2:0 top row sums live in a
// line store of (MAX_WIDTH+1)/2 entries, no clearing.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr_subsampler import rys_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration writes
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  // pixel input
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [PIX_W-1:0]  s_axis_tdata,   // pixel_word
  // sample output
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [39:0]            m_axis_tdata,   // sample_value, column, row, pad
  output logic [2:0]             m_axis_tuser,   // plane, last_of_item
  output logic                   m_axis_tlast    // last_of_frame
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int IDX_W      = LINE_DEPTH > 1 ? $clog2(LINE_DEPTH) : 1;

  logic [2:0]       fmt_q;
  logic             deep_q;
  logic [1:0]       layout_q;
  logic [CFG_W-1:0] width_q, height_q;

  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [SIZE_W-1:0] wid, hgt;
  logic             last_col, last_row, accept, adv;
  ctl_t             ctl_d, ctla_q, ctld;
  logic             va_q;
  logic [PIX_W-1:0] pix_q;
  logic [IDX_W-1:0] idxa_q, idx_c, idxd;
  logic             valid_c, valid_d, ser_free;
  logic signed [CHR_W-1:0] y, u, v;
  item_t            item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_RGB8;
      deep_q   <= 1'b0;
      layout_q <= LAYOUT_420;
      width_q  <= CFG_W'(1920);
      height_q <= CFG_W'(1080);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SOURCE_FORMAT: fmt_q    <= cfg_wdata_i[2:0];
        CFG_DEEP_OUTPUT:   deep_q   <= cfg_wdata_i[0];
        CFG_CHROMA_LAYOUT: layout_q <= cfg_wdata_i[1:0];
        CFG_FRAME_WIDTH:   width_q  <= cfg_wdata_i;
        CFG_FRAME_HEIGHT:  height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (width_q == '0)                           wid = SIZE_W'(1);
    else if (SIZE_W'(width_q) > SIZE_W'(MAX_WIDTH)) wid = SIZE_W'(MAX_WIDTH);
    else                                         wid = SIZE_W'(width_q);
    if (height_q == '0)                            hgt = SIZE_W'(1);
    else if (SIZE_W'(height_q) > SIZE_W'(MAX_HEIGHT)) hgt = SIZE_W'(MAX_HEIGHT);
    else                                           hgt = SIZE_W'(height_q);
  end

  assign last_col = SIZE_W'(col_q) + SIZE_W'(1) >= wid;
  assign last_row = SIZE_W'(row_q) + SIZE_W'(1) >= hgt;

  // per pixel chroma decisions
  always_comb begin
    logic sub, is420, closes;
    sub    = layout_q == LAYOUT_420 || layout_q == LAYOUT_422;
    is420  = layout_q == LAYOUT_420;
    closes = sub && (col_q[0] || last_col);
    ctl_d.fmt        = fmt_q;
    ctl_d.deep       = deep_q;
    ctl_d.col        = POS_W'(col_q);
    ctl_d.row        = POS_W'(row_q);
    ctl_d.ccol       = layout_q == LAYOUT_444 ? POS_W'(col_q) : POS_W'(col_q >> 1);
    ctl_d.crow       = is420 ? POS_W'(row_q >> 1) : POS_W'(row_q);
    ctl_d.last_frame = last_col && last_row;
    ctl_d.pend_wr    = sub && !col_q[0] && !last_col;
    ctl_d.line_wr    = is420 && closes && !row_q[0] && !last_row;
    ctl_d.use_line   = is420 && closes && row_q[0];
    ctl_d.use_pend   = closes && col_q[0];
    ctl_d.chroma_out = layout_q == LAYOUT_444 || (closes && !ctl_d.line_wr);
    ctl_d.avg_sh     = {1'b0, ctl_d.use_pend} + {1'b0, ctl_d.use_line};
  end

  // pipe moves whenever the last stage can hand over
  assign adv           = !valid_d || ser_free;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= last_col ? '0 : col_q + COL_W'(1);
      if (last_col) row_q <= last_row ? '0 : row_q + ROW_W'(1);
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (adv) va_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q  <= s_axis_tdata;
      ctla_q <= ctl_d;
      idxa_q <= IDX_W'(col_q >> 1);
    end
  end

  rys_color_matrix #(.IDX_W(IDX_W)) u_matrix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (va_q),
    .pixel_i   (pix_q),
    .ctl_i     (ctla_q),
    .idx_i     (idxa_q),
    .valid_c_o (valid_c),
    .idx_c_o   (idx_c),
    .valid_o   (valid_d),
    .ctl_o     (ctld),
    .idx_o     (idxd),
    .y_o       (y),
    .u_o       (u),
    .v_o       (v)
  );

  rys_chroma_avg #(.IDX_W(IDX_W), .LINE_DEPTH(LINE_DEPTH)) u_chroma (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_c_i (valid_c),
    .idx_c_i   (idx_c),
    .valid_i   (valid_d),
    .ctl_i     (ctld),
    .idx_i     (idxd),
    .y_i       (y),
    .u_i       (u),
    .v_i       (v),
    .item_o    (item)
  );

  rys_out_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (valid_d && ser_free),
    .item_i        (item),
    .free_o        (ser_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

>>> src/rys_color_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rys_color_matrix
// Unpacks the pixel and computes signed Y, U, V over three register stages.
// ----------------------------------------------------------------------------
module rys_color_matrix import rys_pkg::*; #(
  parameter int IDX_W = 11
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    adv_i,
  input  wire logic                    valid_i,
  input  wire logic [PIX_W-1:0]        pixel_i,
  input  wire ctl_t                    ctl_i,
  input  wire logic [IDX_W-1:0]        idx_i,
  output logic                         valid_c_o,
  output logic [IDX_W-1:0]             idx_c_o,
  output logic                         valid_o,
  output ctl_t                         ctl_o,
  output logic [IDX_W-1:0]             idx_o,
  output logic signed [CHR_W-1:0]      y_o,
  output logic signed [CHR_W-1:0]      u_o,
  output logic signed [CHR_W-1:0]      v_o
);

  logic [COMP_W-1:0]              comp [3];
  logic signed [PROD_W-1:0]       prod_d [3][3];
  logic signed [PROD_W-1:0]       prod_q [3][3];
  logic                           vb_q, vc_q, vd_q;
  ctl_t                           ctlb_q, ctlc_q, ctld_q;
  logic [IDX_W-1:0]               idxb_q, idxc_q, idxd_q;
  logic [ABS_W-1:0]               abs_d [3];
  logic [ABS_W-1:0]               abs_q [3];
  logic                           neg_d [3];
  logic                           neg_q [3];
  logic signed [CHR_W-1:0]        res_d [3];
  logic signed [CHR_W-1:0]        res_q [3];

  // component unpack by source format and output depth
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (ctl_i.fmt)
        FMT_RGB10, FMT_RGB10A2: begin
          if (ctl_i.deep) comp[k] = pixel_i[10*k +: 10];
          else            comp[k] = {2'b00, pixel_i[10*k+2 +: 8]};
        end
        FMT_RGB16, FMT_RGBA16: begin
          if (ctl_i.deep) comp[k] = pixel_i[16*k+6 +: 10];
          else            comp[k] = {2'b00, pixel_i[16*k+8 +: 8]};
        end
        default: begin
          if (ctl_i.deep) comp[k] = {pixel_i[8*k +: 8], pixel_i[8*k+6 +: 2]};
          else            comp[k] = {2'b00, pixel_i[8*k +: 8]};
        end
      endcase
    end
  end

  // weighted products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[i][k] = $signed({{(PROD_W-COMP_W){1'b0}}, comp[k]}) * COEF[i][k];
      end
    end
  end

  // sums split into magnitude and sign
  always_comb begin
    logic signed [PROD_W-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      sum      = prod_q[i][0] + prod_q[i][1] + prod_q[i][2];
      neg_d[i] = sum[PROD_W-1];
      abs_d[i] = neg_d[i] ? ABS_W'(-sum) : ABS_W'(sum);
    end
  end

  // truncating divide by 100000 through the reciprocal
  always_comb begin
    logic [ABS_W+PROD_W-1:0] p;
    logic [CHR_W-1:0]        q;
    for (int i = 0; i < 3; i++) begin
      p        = abs_q[i] * RECIP;
      q        = {1'b0, p[RECIP_SH +: SAMPLE_W]};
      res_d[i] = neg_q[i] ? -$signed(q) : $signed(q);
    end
  end

  // valid flags of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (adv_i) begin
      vb_q <= valid_i;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctlb_q <= ctl_i;
      idxb_q <= idx_i;
      prod_q <= prod_d;
      ctlc_q <= ctlb_q;
      idxc_q <= idxb_q;
      abs_q  <= abs_d;
      neg_q  <= neg_d;
      ctld_q <= ctlc_q;
      idxd_q <= idxc_q;
      res_q  <= res_d;
    end
  end

  assign valid_c_o = vc_q;
  assign idx_c_o   = idxc_q;
  assign valid_o   = vd_q;
  assign ctl_o     = ctld_q;
  assign idx_o     = idxd_q;
  assign y_o       = res_q[0];
  assign u_o       = res_q[1];
  assign v_o       = res_q[2];

endmodule
`default_nettype wire

>>> src/rys_chroma_avg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rys_chroma_avg
// Pair and quad chroma averaging with the pending pair and top row line store.
// ----------------------------------------------------------------------------
module rys_chroma_avg import rys_pkg::*; #(
  parameter int IDX_W      = 11,
  parameter int LINE_DEPTH = 2048
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    adv_i,
  input  wire logic                    valid_c_i,
  input  wire logic [IDX_W-1:0]        idx_c_i,
  input  wire logic                    valid_i,
  input  wire ctl_t                    ctl_i,
  input  wire logic [IDX_W-1:0]        idx_i,
  input  wire logic signed [CHR_W-1:0] y_i,
  input  wire logic signed [CHR_W-1:0] u_i,
  input  wire logic signed [CHR_W-1:0] v_i,
  output item_t                        item_o
);

  logic [2*CHR_W-1:0]      line_mem [LINE_DEPTH];
  logic [2*CHR_W-1:0]      rd_q;
  logic [2*CHR_W-1:0]      pend_q;
  logic [2*CHR_W-1:0]      wdata;
  logic                    line_we;
  logic signed [SUM_W-1:0] su, sv;

  function automatic logic signed [SUM_W-1:0] sext(input logic [CHR_W-1:0] x);
    return SUM_W'($signed(x));
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp(input logic signed [SUM_W-1:0] x,
                                                input logic deep);
    logic signed [SUM_W-1:0] top;
    top = deep ? SUM_W'(1023) : SUM_W'(255);
    if (x < 0)        return '0;
    else if (x > top) return top[SAMPLE_W-1:0];
    else              return x[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] finish(input logic signed [SUM_W-1:0] s,
                                                 input logic [1:0] sh,
                                                 input logic deep);
    logic signed [SUM_W-1:0] bias;
    logic signed [SUM_W-1:0] q;
    logic signed [SUM_W-1:0] half;
    bias = s < 0 ? SUM_W'((3'd1 << sh) - 3'd1) : '0;
    q    = (s + bias) >>> sh;
    half = deep ? SUM_W'(512) : SUM_W'(128);
    return clamp(q + half, deep);
  endfunction

  // sums over the pair and the row pair
  always_comb begin
    su = sext(u_i);
    sv = sext(v_i);
    if (ctl_i.use_pend) begin
      su = su + sext(pend_q[CHR_W-1:0]);
      sv = sv + sext(pend_q[2*CHR_W-1:CHR_W]);
    end
    if (ctl_i.use_line) begin
      su = su + sext(rd_q[CHR_W-1:0]);
      sv = sv + sext(rd_q[2*CHR_W-1:CHR_W]);
    end
  end

  assign wdata   = {sv[CHR_W-1:0], su[CHR_W-1:0]};
  assign line_we = adv_i && valid_i && ctl_i.line_wr;

  // line store write
  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[idx_i] <= wdata;
  end

  // line store read one stage ahead, with bypass of the write in flight
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_c_i) begin
      if (line_we && idx_c_i == idx_i) rd_q <= wdata;
      else                             rd_q <= line_mem[idx_c_i];
    end
  end

  // chroma of the even pixel of a pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (adv_i && valid_i && ctl_i.pend_wr) begin
      pend_q <= {v_i, u_i};
    end
  end

  // final samples
  always_comb begin
    item_o.y_val      = clamp(sext(y_i), ctl_i.deep);
    item_o.cb_val     = finish(su, ctl_i.avg_sh, ctl_i.deep);
    item_o.cr_val     = finish(sv, ctl_i.avg_sh, ctl_i.deep);
    item_o.col        = ctl_i.col;
    item_o.row        = ctl_i.row;
    item_o.ccol       = ctl_i.ccol;
    item_o.crow       = ctl_i.crow;
    item_o.chroma_out = ctl_i.chroma_out;
    item_o.last_frame = ctl_i.last_frame;
  end

endmodule
`default_nettype wire

>>> src/rys_out_ser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rys_out_ser
// Result register that sends the samples of one pixel one request at a time.
// ----------------------------------------------------------------------------
module rys_out_ser import rys_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire item_t       item_i,
  output logic             free_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  logic       v_q;
  item_t      it_q;
  logic [1:0] k_q;
  logic [1:0] last_k;
  logic       take, done;
  logic [SAMPLE_W-1:0] val;
  plane_e              plane;
  logic [POS_W-1:0]    pcol, prow;

  assign last_k = it_q.chroma_out ? 2'd2 : 2'd0;
  assign take   = v_q && m_axis_tready;
  assign done   = take && (k_q == last_k);
  assign free_o = !v_q || done;

  // request sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
      k_q <= 2'd0;
    end else if (load_i) begin
      v_q <= 1'b1;
      k_q <= 2'd0;
    end else if (done) begin
      v_q <= 1'b0;
    end else if (take) begin
      k_q <= k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) it_q <= item_i;
  end

  // sample select
  always_comb begin
    unique case (k_q)
      2'd0: begin
        val = it_q.y_val;  plane = PLANE_Y;  pcol = it_q.col;  prow = it_q.row;
      end
      2'd1: begin
        val = it_q.cb_val; plane = PLANE_CB; pcol = it_q.ccol; prow = it_q.crow;
      end
      default: begin
        val = it_q.cr_val; plane = PLANE_CR; pcol = it_q.ccol; prow = it_q.crow;
      end
    endcase
  end

  assign m_axis_tvalid = v_q;
  assign m_axis_tdata  = {6'd0, prow, pcol, val};
  assign m_axis_tuser  = {k_q == last_k, plane};
  assign m_axis_tlast  = it_q.last_frame && (k_q == last_k);

endmodule
`default_nettype wire

>>> src/rys_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rys_checker
// Port level checks on the sample output of the subsampler.
// ----------------------------------------------------------------------------
module rys_checker import rys_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // stalled request holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request dropped or changed under stall");

  // frame end is always the last sample of its pixel
  a_tlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2])
    else $error("frame end not on last sample of pixel");

  // cb never closes a pixel
  a_cb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == PLANE_CB |-> !m_axis_tuser[2])
    else $error("cb sample marked last");

  // cr always closes a pixel
  a_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == PLANE_CR |-> m_axis_tuser[2])
    else $error("cr sample not marked last");

  // cb is followed by cr once taken
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[1:0] == PLANE_CB
      |=> m_axis_tvalid && m_axis_tuser[1:0] == PLANE_CR)
    else $error("cr does not follow cb");

endmodule

bind rgb_to_ycbcr_subsampler rys_checker u_rys_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
